[rtl/sfe_pkg.sv]
`timescale 1ns / 1ps

package sfe_pkg;

    // Signed exponent wide enough for every intermediate scale in the chain.
    localparam int EW = 13;
    typedef logic signed [EW-1:0] exp_t;

    localparam logic [1:0] KIND_ZERO = 2'd0;
    localparam logic [1:0] KIND_FIN  = 2'd1;
    localparam logic [1:0] KIND_INF  = 2'd2;
    localparam logic [1:0] KIND_NAN  = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic       s;
        logic [23:0] m;
        exp_t       e;
    } fval_t;

    localparam logic [31:0] QBIT = 32'h0040_0000;
    localparam logic [31:0] DNAN = 32'hFFC0_0000;
    localparam logic [31:0] INFB = 32'h7F80_0000;

    localparam logic [31:0] K_LOG2E     = 32'h3FB8_AA3B;
    localparam logic [31:0] K_LN2_HI_N  = 32'hBF31_7200;
    localparam logic [31:0] K_LN2_LO_N  = 32'hB5BF_BE8E;
    localparam logic [31:0] K_C4        = 32'h3D2B_CDE1;
    localparam logic [31:0] K_C3        = 32'h3E2C_09F1;
    localparam logic [31:0] K_C2        = 32'h3EFF_FFFE;
    localparam logic [31:0] K_C1        = 32'h3F7F_FD2D;
    localparam logic [31:0] K_C0        = 32'h3F7F_FFFA;

    function automatic fval_t unpack(input logic [31:0] b);
        fval_t v;
        v.s    = b[31];
        v.m    = '0;
        v.e    = '0;
        v.kind = KIND_ZERO;
        if (b[30:23] == 8'hFF) begin
            v.kind = (b[22:0] != 23'd0) ? KIND_NAN : KIND_INF;
        end
        else if (b[30:23] == 8'h00) begin
            if (b[22:0] != 23'd0) begin
                v.kind = KIND_FIN;
                v.m    = {1'b0, b[22:0]};
                v.e    = exp_t'(-149);
            end
        end
        else begin
            v.kind = KIND_FIN;
            v.m    = {1'b1, b[22:0]};
            v.e    = exp_t'({5'd0, b[30:23]}) - exp_t'(150);
        end
        return v;
    endfunction

    // Leading zero count; 64 for an all-zero word.
    function automatic logic [6:0] clz64(input logic [63:0] m);
        logic [6:0] n;
        logic       hit;
        n   = 7'd64;
        hit = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!hit && m[i]) begin
                n   = 7'(63 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    // Round s * m * 2^e to binary32, nearest even; m has bit 63 set.
    function automatic logic [31:0] round_pack(input logic s, input logic [63:0] m,
                                               input exp_t e);
        exp_t        big;
        exp_t        shs;
        logic [6:0]  sh;
        logic [24:0] q;
        logic        half;
        logic        rest;
        logic        inc;
        logic [63:0] mask;
        logic [7:0]  ef;
        logic [32:0] bits;
        big  = e + exp_t'(63);
        shs  = exp_t'(-149) - e;
        mask = '0;
        if (shs < exp_t'(40)) sh = 7'd40;
        else if (shs > exp_t'(64)) sh = 7'd65;
        else sh = shs[6:0];
        if (sh == 7'd64) begin
            q    = '0;
            half = m[63];
            rest = |m[62:0];
        end
        else begin
            q    = 25'(m >> sh);
            half = m[6'(sh - 7'd1)];
            mask = (64'd1 << (sh - 7'd1)) - 64'd1;
            rest = |(m & mask);
        end
        inc  = half & (rest | q[0]);
        q    = q + 25'(inc);
        ef   = (sh == 7'd40) ? 8'(big + exp_t'(126)) : 8'd0;
        bits = {2'd0, ef, 23'd0} + {8'd0, q};
        if (bits >= {1'b0, INFB}) bits = {1'b0, INFB};
        if (big > exp_t'(127)) return {s, INFB[30:0]};
        if (sh > 7'd64) return {s, 31'd0};
        return {s, bits[30:0]};
    endfunction

endpackage

[rtl/sfe_fma.sv]
`timescale 1ns / 1ps

// Fused multiply-add a*b+c, five register stages, one transaction per cycle.
module sfe_fma #(
    parameter int SIDE_W = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    input  logic [31:0]       c,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [31:0]       result,
    output logic [SIDE_W-1:0] side_out
);
    import sfe_pkg::*;

    logic [4:0] v_reg;

    // stage 1: classify, multiply
    fval_t       ua, ub, uc;
    logic        ps, pinf, pzero, spec_next;
    logic [31:0] sv_next;
    logic        spec1_reg, ps1_reg, cs1_reg, cz1_reg;
    logic [31:0] sv1_reg;
    logic [47:0] pm1_reg;
    exp_t        pe1_reg, ce1_reg;
    logic [23:0] cm1_reg;
    logic [SIDE_W-1:0] side1_reg;

    always_comb
    begin
        ua        = unpack(a);
        ub        = unpack(b);
        uc        = unpack(c);
        ps        = ua.s ^ ub.s;
        pinf      = (ua.kind == KIND_INF) || (ub.kind == KIND_INF);
        pzero     = (ua.kind == KIND_ZERO) || (ub.kind == KIND_ZERO);
        spec_next = 1'b1;
        sv_next   = '0;
        if (ua.kind == KIND_NAN) sv_next = a | QBIT;
        else if (ub.kind == KIND_NAN) sv_next = b | QBIT;
        else if (uc.kind == KIND_NAN) sv_next = c | QBIT;
        else if (pinf && pzero) sv_next = DNAN;
        else if (pinf) begin
            if (uc.kind == KIND_INF && uc.s != ps) sv_next = DNAN;
            else sv_next = {ps, INFB[30:0]};
        end
        else if (uc.kind == KIND_INF) sv_next = c;
        else if (pzero) begin
            if (uc.kind == KIND_ZERO) sv_next = {ps & uc.s, 31'd0};
            else sv_next = c;
        end
        else spec_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        spec1_reg <= spec_next;
        sv1_reg   <= sv_next;
        ps1_reg   <= ps;
        pm1_reg   <= ua.m * ub.m;
        pe1_reg   <= ua.e + ub.e;
        cs1_reg   <= uc.s;
        cm1_reg   <= uc.m;
        ce1_reg   <= uc.e;
        cz1_reg   <= (uc.kind == KIND_ZERO);
        side1_reg <= side_in;
    end

    // stage 2: bring both addends to bit 61
    logic [6:0]  lzp, lzc;
    logic        spec2_reg, ps2_reg, cs2_reg, cz2_reg;
    logic [31:0] sv2_reg;
    logic [63:0] pm2_reg, cm2_reg;
    exp_t        pe2_reg, ce2_reg;
    logic [SIDE_W-1:0] side2_reg;

    assign lzp = clz64({16'd0, pm1_reg});
    assign lzc = clz64({40'd0, cm1_reg});

    always_ff @(posedge clk)
    begin
        spec2_reg <= spec1_reg;
        sv2_reg   <= sv1_reg;
        ps2_reg   <= ps1_reg;
        cs2_reg   <= cs1_reg;
        cz2_reg   <= cz1_reg;
        pm2_reg   <= {16'd0, pm1_reg} << (lzp - 7'd2);
        pe2_reg   <= pe1_reg - (exp_t'(lzp) - exp_t'(2));
        cm2_reg   <= {40'd0, cm1_reg} << (lzc - 7'd2);
        ce2_reg   <= ce1_reg - (exp_t'(lzc) - exp_t'(2));
        side2_reg <= side1_reg;
    end

    // stage 3: order, align with sticky, add
    logic        pbig, sb, ssm, lost;
    logic [63:0] mb, msm, msm_al, sum;
    exp_t        eb, es, d;
    logic        spec3_reg, s3_reg;
    logic [31:0] sv3_reg;
    logic [63:0] sum3_reg;
    exp_t        e3_reg;
    logic [SIDE_W-1:0] side3_reg;

    always_comb
    begin
        pbig = cz2_reg || (pe2_reg > ce2_reg) ||
               ((pe2_reg == ce2_reg) && (pm2_reg >= cm2_reg));
        mb   = pbig ? pm2_reg : cm2_reg;
        eb   = pbig ? pe2_reg : ce2_reg;
        sb   = pbig ? ps2_reg : cs2_reg;
        msm  = pbig ? cm2_reg : pm2_reg;
        es   = pbig ? ce2_reg : pe2_reg;
        ssm  = pbig ? cs2_reg : ps2_reg;
        d    = eb - es;
        lost = 1'b0;
        if (cz2_reg) msm_al = '0;
        else if (d >= exp_t'(62)) msm_al = 64'd1;
        else begin
            lost   = |(msm & ((64'd1 << d[5:0]) - 64'd1));
            msm_al = (msm >> d[5:0]) | {63'd0, lost};
        end
        sum = (sb == ssm) ? (mb + msm_al) : (mb - msm_al);
    end

    always_ff @(posedge clk)
    begin
        spec3_reg <= spec2_reg;
        sv3_reg   <= sv2_reg;
        s3_reg    <= sb;
        sum3_reg  <= sum;
        e3_reg    <= eb;
        side3_reg <= side2_reg;
    end

    // stage 4: normalize the sum
    logic [6:0]  lzs;
    logic        spec4_reg, s4_reg, z4_reg;
    logic [31:0] sv4_reg;
    logic [63:0] m4_reg;
    exp_t        e4_reg;
    logic [SIDE_W-1:0] side4_reg;

    assign lzs = clz64(sum3_reg);

    always_ff @(posedge clk)
    begin
        spec4_reg <= spec3_reg;
        sv4_reg   <= sv3_reg;
        s4_reg    <= s3_reg;
        z4_reg    <= (sum3_reg == 64'd0);
        m4_reg    <= sum3_reg << lzs;
        e4_reg    <= e3_reg - exp_t'(lzs);
        side4_reg <= side3_reg;
    end

    // stage 5: round
    logic [31:0] res_next;
    logic [31:0] res_reg;
    logic [SIDE_W-1:0] side5_reg;

    always_comb
    begin
        if (spec4_reg) res_next = sv4_reg;
        else if (z4_reg) res_next = 32'd0;
        else res_next = round_pack(s4_reg, m4_reg, e4_reg);
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        side5_reg <= side4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_reg <= '0;
        else v_reg <= {v_reg[3:0], in_valid};
    end

    assign out_valid = v_reg[4];
    assign result    = res_reg;
    assign side_out  = side5_reg;

endmodule

[rtl/single_float_exp_approx_core.sv]
`timescale 1ns / 1ps

// Single-precision exp(x) approximation. A transaction is accepted on every
// cycle that start is high (busy is always low), and its result appears on y_bits
// with done high for exactly one cycle; transactions come out in order, one per
// cycle at full rate. The pipeline is made of these stages:
// four for x*log2(e) and round-to-integer, five for each of the six fused
// multiply-adds (range reduction and Horner polynomial), and three for the
// final scale by 2^r. The receiver cannot stall, so no buffering is needed.
module single_float_exp_approx_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] x_bits,
    output logic        done,
    output logic [31:0] y_bits
);
    import sfe_pkg::*;

    // never holds off a transaction
    assign busy = 1'b0;

    logic [3:0] fv_reg;

    // t = x * log2(e): classify and multiply
    fval_t       ux, uk;
    logic        ms, m_spec_next;
    logic [31:0] m_sv_next;
    logic        m1_spec_reg, m1_s_reg;
    logic [31:0] m1_sv_reg, m1_x_reg;
    logic [47:0] m1_p_reg;
    exp_t        m1_e_reg;

    always_comb
    begin
        ux          = unpack(x_bits);
        uk          = unpack(K_LOG2E);
        ms          = ux.s ^ uk.s;
        m_spec_next = 1'b1;
        m_sv_next   = '0;
        if (ux.kind == KIND_NAN) m_sv_next = x_bits | QBIT;
        else if (uk.kind == KIND_NAN) m_sv_next = K_LOG2E | QBIT;
        else if (ux.kind == KIND_INF || uk.kind == KIND_INF) begin
            if (ux.kind == KIND_ZERO || uk.kind == KIND_ZERO) m_sv_next = DNAN;
            else m_sv_next = {ms, INFB[30:0]};
        end
        else if (ux.kind == KIND_ZERO || uk.kind == KIND_ZERO) m_sv_next = {ms, 31'd0};
        else m_spec_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        m1_spec_reg <= m_spec_next;
        m1_sv_reg   <= m_sv_next;
        m1_s_reg    <= ms;
        m1_p_reg    <= ux.m * uk.m;
        m1_e_reg    <= ux.e + uk.e;
        m1_x_reg    <= x_bits;
    end

    // normalize the product
    logic [6:0]  m_lz;
    logic        m2_spec_reg, m2_s_reg;
    logic [31:0] m2_sv_reg, m2_x_reg;
    logic [63:0] m2_m_reg;
    exp_t        m2_e_reg;

    assign m_lz = clz64({16'd0, m1_p_reg});

    always_ff @(posedge clk)
    begin
        m2_spec_reg <= m1_spec_reg;
        m2_sv_reg   <= m1_sv_reg;
        m2_s_reg    <= m1_s_reg;
        m2_m_reg    <= {16'd0, m1_p_reg} << m_lz;
        m2_e_reg    <= m1_e_reg - exp_t'(m_lz);
        m2_x_reg    <= m1_x_reg;
    end

    // round the product to t
    logic [31:0] m3_t_reg, m3_x_reg;

    always_ff @(posedge clk)
    begin
        m3_t_reg <= m2_spec_reg ? m2_sv_reg : round_pack(m2_s_reg, m2_m_reg, m2_e_reg);
        m3_x_reg <= m2_x_reg;
    end

    // r = round t to an integer, ties to even, sign of zero kept
    logic [7:0]  tbe;
    logic [23:0] tm;
    logic [4:0]  tsh;
    logic [24:0] tq;
    logic        thalf, trest;
    logic [4:0]  tpos;
    logic [7:0]  texp;
    logic [22:0] tfrac;
    logic [31:0] r_next;
    logic [31:0] m4_r_reg, m4_x_reg;

    always_comb
    begin
        tbe   = m3_t_reg[30:23];
        tm    = {tbe != 8'd0, m3_t_reg[22:0]};
        tsh   = 5'((9'd150 - {1'b0, tbe}));
        tq    = '0;
        thalf = 1'b0;
        trest = 1'b0;
        tpos  = '0;
        texp  = '0;
        tfrac = '0;
        if (tbe == 8'hFF && m3_t_reg[22:0] != 23'd0) r_next = m3_t_reg | QBIT;
        else if (tbe == 8'hFF || (tbe == 8'd0 && m3_t_reg[22:0] == 23'd0) || tbe >= 8'd150)
            r_next = m3_t_reg;
        else if (tbe < 8'd126) r_next = {m3_t_reg[31], 31'd0};
        else begin
            tq    = {1'b0, tm >> tsh};
            thalf = tm[tsh - 5'd1];
            trest = |(tm & ((24'd1 << (tsh - 5'd1)) - 24'd1));
            tq    = tq + 25'(thalf & (trest | tq[0]));
            for (int i = 0; i < 25; i++) begin
                if (tq[i]) tpos = 5'(i);
            end
            texp  = 8'(8'd127 + {3'd0, tpos});
            tfrac = (tpos == 5'd24) ? 23'd0 : 23'(tq << (5'd23 - tpos));
            if (tq == 25'd0) r_next = {m3_t_reg[31], 31'd0};
            else r_next = {m3_t_reg[31], texp, tfrac};
        end
    end

    always_ff @(posedge clk)
    begin
        m4_r_reg <= r_next;
        m4_x_reg <= m3_x_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) fv_reg <= '0;
        else fv_reg <= {fv_reg[2:0], start & ~busy};
    end

    // range reduction: f = x - r*ln2_hi - r*ln2_lo
    logic        f1_v, f2_v;
    logic [31:0] f1, f2, f1_r, f2_r;

    sfe_fma #(.SIDE_W(32)) u_red_hi (
        .clk(clk), .rst_n(rst_n), .in_valid(fv_reg[3]),
        .a(m4_r_reg), .b(K_LN2_HI_N), .c(m4_x_reg), .side_in(m4_r_reg),
        .out_valid(f1_v), .result(f1), .side_out(f1_r)
    );

    sfe_fma #(.SIDE_W(32)) u_red_lo (
        .clk(clk), .rst_n(rst_n), .in_valid(f1_v),
        .a(f1_r), .b(K_LN2_LO_N), .c(f1), .side_in(f1_r),
        .out_valid(f2_v), .result(f2), .side_out(f2_r)
    );

    // Horner polynomial in f; carry {r, f} alongside
    logic        p3_v, p4_v, p5_v, p6_v;
    logic [31:0] p3, p4, p5, p6, p6_r;
    logic [63:0] p3_side, p4_side, p5_side;

    sfe_fma #(.SIDE_W(64)) u_poly3 (
        .clk(clk), .rst_n(rst_n), .in_valid(f2_v),
        .a(K_C4), .b(f2), .c(K_C3), .side_in({f2_r, f2}),
        .out_valid(p3_v), .result(p3), .side_out(p3_side)
    );

    sfe_fma #(.SIDE_W(64)) u_poly2 (
        .clk(clk), .rst_n(rst_n), .in_valid(p3_v),
        .a(p3), .b(p3_side[31:0]), .c(K_C2), .side_in(p3_side),
        .out_valid(p4_v), .result(p4), .side_out(p4_side)
    );

    sfe_fma #(.SIDE_W(64)) u_poly1 (
        .clk(clk), .rst_n(rst_n), .in_valid(p4_v),
        .a(p4), .b(p4_side[31:0]), .c(K_C1), .side_in(p4_side),
        .out_valid(p5_v), .result(p5), .side_out(p5_side)
    );

    sfe_fma #(.SIDE_W(32)) u_poly0 (
        .clk(clk), .rst_n(rst_n), .in_valid(p5_v),
        .a(p5), .b(p5_side[31:0]), .c(K_C0), .side_in(p5_side[63:32]),
        .out_valid(p6_v), .result(p6), .side_out(p6_r)
    );

    // scale p by 2^r: specials and the saturated shift count
    fval_t       up, ur;
    logic        c_spec_next, rfr;
    logic [31:0] c_sv_next;
    exp_t        rsh;
    logic [23:0] rip;
    logic [24:0] rv;
    logic [9:0]  kv;
    exp_t        kk;
    logic [2:0]  cv_reg;
    logic        c1_spec_reg, c1_s_reg;
    logic [31:0] c1_sv_reg;
    logic [23:0] c1_m_reg;
    exp_t        c1_e_reg;

    always_comb
    begin
        up          = unpack(p6);
        ur          = unpack(p6_r);
        c_spec_next = 1'b1;
        c_sv_next   = '0;
        if (up.kind == KIND_NAN) c_sv_next = p6 | QBIT;
        else if (ur.kind == KIND_NAN) c_sv_next = p6_r | QBIT;
        else if (ur.kind == KIND_INF) begin
            if (ur.s) c_sv_next = (up.kind == KIND_INF) ? DNAN : {up.s, 31'd0};
            else c_sv_next = (up.kind == KIND_ZERO) ? DNAN : {up.s, INFB[30:0]};
        end
        else if (up.kind != KIND_FIN) c_sv_next = p6;
        else c_spec_next = 1'b0;

        rsh = exp_t'(0) - ur.e;
        rip = '0;
        rfr = 1'b0;
        rv  = '0;
        if (ur.kind == KIND_ZERO) kv = 10'd0;
        else if (ur.e >= exp_t'(0)) kv = 10'd1000;
        else begin
            if (rsh >= exp_t'(24)) begin
                rip = '0;
                rfr = |ur.m;
            end
            else begin
                rip = ur.m >> rsh[4:0];
                rfr = |(ur.m & ((24'd1 << rsh[4:0]) - 24'd1));
            end
            rv = {1'b0, rip} + 25'(ur.s & rfr);
            kv = (rv > 25'd1000) ? 10'd1000 : rv[9:0];
        end
        kk = ur.s ? (exp_t'(0) - exp_t'({1'b0, kv})) : exp_t'({1'b0, kv});
    end

    always_ff @(posedge clk)
    begin
        c1_spec_reg <= c_spec_next;
        c1_sv_reg   <= c_sv_next;
        c1_s_reg    <= up.s;
        c1_m_reg    <= up.m;
        c1_e_reg    <= up.e + kk;
    end

    // normalize the mantissa of p
    logic [6:0]  c_lz;
    logic        c2_spec_reg, c2_s_reg;
    logic [31:0] c2_sv_reg;
    logic [63:0] c2_m_reg;
    exp_t        c2_e_reg;

    assign c_lz = clz64({40'd0, c1_m_reg});

    always_ff @(posedge clk)
    begin
        c2_spec_reg <= c1_spec_reg;
        c2_sv_reg   <= c1_sv_reg;
        c2_s_reg    <= c1_s_reg;
        c2_m_reg    <= {40'd0, c1_m_reg} << c_lz;
        c2_e_reg    <= c1_e_reg - exp_t'(c_lz);
    end

    // round and drive the result
    logic [31:0] y_reg;

    always_ff @(posedge clk)
    begin
        y_reg <= c2_spec_reg ? c2_sv_reg : round_pack(c2_s_reg, c2_m_reg, c2_e_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) cv_reg <= '0;
        else cv_reg <= {cv_reg[1:0], p6_v};
    end

    assign done   = cv_reg[2];
    assign y_bits = y_reg;

endmodule
